@@ rtl/h264_start_code_packetizer_macros.svh @@
// ----------------------------------------------------------------------------
// Start code packetizer assertion macros
// Shared property forms for the packetizer's embedded checks.
// ----------------------------------------------------------------------------
`ifndef H264_START_CODE_PACKETIZER_MACROS_SVH
`define H264_START_CODE_PACKETIZER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HSCP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hscp: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define HSCP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hscp: next-cycle check failed");

`endif

@@ rtl/hscp_pkg.sv @@
// ----------------------------------------------------------------------------
// Start code packetizer package
// Constants, control word layout and the sequencer program shared by the
// packetizer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package hscp_pkg;

	// Header store geometry.
	localparam int HEADER_BYTES = 29;
	localparam int SPS_END      = 20;
	localparam int START_LEN    = 5;
	localparam int HDR_AW       = $clog2(HEADER_BYTES);

	localparam logic [HDR_AW-1:0] HDR_LAST     = HDR_AW'(HEADER_BYTES - 1);
	localparam logic [HDR_AW-1:0] HDR_SPS_BODY = HDR_AW'(START_LEN);
	localparam logic [HDR_AW-1:0] HDR_PPS_BASE = HDR_AW'(SPS_END);
	localparam logic [HDR_AW-1:0] HDR_PPS_BODY = HDR_AW'(SPS_END + START_LEN);
	localparam logic [HDR_AW-1:0] HDR_SPS_DONE = HDR_AW'(SPS_END);
	localparam logic [HDR_AW-1:0] HDR_PPS_DONE = HDR_AW'(HEADER_BYTES);

	// Stream byte values.
	localparam logic [7:0] BYTE_ZERO  = 8'h00;
	localparam logic [7:0] BYTE_ONE   = 8'h01;
	localparam logic [7:0] TYPE_CLOSE = 8'h21;
	localparam logic [7:0] TYPE_KEY   = 8'h25;
	localparam logic [7:0] TYPE_SPS   = 8'h27;
	localparam logic [7:0] TYPE_PPS   = 8'h28;
	localparam logic [7:0] TYPE_AUD   = 8'h09;

	// Package capacity register.
	localparam int CAP_W = 12;
	localparam int FILL_W = 11;
	localparam logic [CAP_W-1:0] CAP_RESET = 12'd1024;
	localparam logic [CAP_W-1:0] CAP_MIN   = 12'd32;
	localparam logic [CAP_W-1:0] CAP_MAX   = 12'd2048;

	// Result kinds.
	localparam logic KIND_BYTE  = 1'b0;
	localparam logic KIND_CLOSE = 1'b1;

	// Control word opcodes and byte sources.
	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_CLOSE  = 1'b1;

	localparam logic [1:0] SRC_ZERO = 2'd0;
	localparam logic [1:0] SRC_ONE  = 2'd1;
	localparam logic [1:0] SRC_BYTE = 2'd2;
	localparam logic [1:0] SRC_HDR  = 2'd3;

	// Program addresses.
	localparam int UC_AW = 4;
	localparam logic [UC_AW-1:0] UC_PASS3 = 4'd0;
	localparam logic [UC_AW-1:0] UC_PASS2 = 4'd1;
	localparam logic [UC_AW-1:0] UC_PASS1 = 4'd2;
	localparam logic [UC_AW-1:0] UC_BYTE  = 4'd3;
	localparam logic [UC_AW-1:0] UC_CLOSE = 4'd4;
	localparam logic [UC_AW-1:0] UC_KEY   = 4'd5;
	localparam logic [UC_AW-1:0] UC_START = 4'd6;
	localparam logic [UC_AW-1:0] UC_SC1   = 4'd7;
	localparam logic [UC_AW-1:0] UC_SC2   = 4'd8;
	localparam logic [UC_AW-1:0] UC_SC3   = 4'd9;
	localparam logic [UC_AW-1:0] UC_TYPE  = 4'd10;
	localparam logic [UC_AW-1:0] UC_HDR   = 4'd11;
	localparam logic [UC_AW-1:0] UC_LAST  = UC_HDR;

	typedef struct packed {
		logic             op;
		logic [1:0]       src;
		logic             new_frame;
		logic             save_on;
		logic             fin;
		logic             hdr_loop;
		logic [UC_AW-1:0] nxt;
	} ucode_t;

	// Scanner to sequencer: start a program for the byte just taken.
	typedef struct packed {
		logic             valid;
		logic [UC_AW-1:0] entry;
		logic [7:0]       data;
	} start_req_t;

	// Sequencer to scanner status.
	typedef struct packed {
		logic idle;
		logic saving;
	} seq_stat_t;

	function automatic ucode_t uc_word(input logic op, input logic [1:0] src,
			input logic new_frame, input logic save_on, input logic fin,
			input logic hdr_loop, input logic [UC_AW-1:0] nxt);
		ucode_t w;
		w.op        = op;
		w.src       = src;
		w.new_frame = new_frame;
		w.save_on   = save_on;
		w.fin       = fin;
		w.hdr_loop  = hdr_loop;
		w.nxt       = nxt;
		return w;
	endfunction

	// Program ROM. Final steps point at themselves.
	function automatic ucode_t uc_rom(input logic [UC_AW-1:0] addr);
		ucode_t w;
		unique case (addr)
			UC_PASS3: w = uc_word(OP_APPEND, SRC_ZERO, 1'b0, 1'b0, 1'b0, 1'b0, UC_PASS2);
			UC_PASS2: w = uc_word(OP_APPEND, SRC_ZERO, 1'b0, 1'b0, 1'b0, 1'b0, UC_PASS1);
			UC_PASS1: w = uc_word(OP_APPEND, SRC_ZERO, 1'b0, 1'b0, 1'b0, 1'b0, UC_BYTE);
			UC_BYTE:  w = uc_word(OP_APPEND, SRC_BYTE, 1'b0, 1'b0, 1'b1, 1'b0, UC_BYTE);
			UC_CLOSE: w = uc_word(OP_CLOSE,  SRC_ZERO, 1'b0, 1'b0, 1'b0, 1'b0, UC_START);
			UC_KEY:   w = uc_word(OP_CLOSE,  SRC_ZERO, 1'b1, 1'b1, 1'b0, 1'b0, UC_START);
			UC_START: w = uc_word(OP_APPEND, SRC_ZERO, 1'b0, 1'b0, 1'b0, 1'b0, UC_SC1);
			UC_SC1:   w = uc_word(OP_APPEND, SRC_ZERO, 1'b0, 1'b0, 1'b0, 1'b0, UC_SC2);
			UC_SC2:   w = uc_word(OP_APPEND, SRC_ZERO, 1'b0, 1'b0, 1'b0, 1'b0, UC_SC3);
			UC_SC3:   w = uc_word(OP_APPEND, SRC_ONE,  1'b0, 1'b0, 1'b0, 1'b0, UC_TYPE);
			UC_TYPE:  w = uc_word(OP_APPEND, SRC_BYTE, 1'b0, 1'b0, 1'b1, 1'b0, UC_TYPE);
			UC_HDR:   w = uc_word(OP_APPEND, SRC_HDR,  1'b0, 1'b0, 1'b1, 1'b1, UC_HDR);
			default:  w = uc_word(OP_APPEND, SRC_BYTE, 1'b0, 1'b0, 1'b1, 1'b0, UC_BYTE);
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

@@ rtl/hscp_if.sv @@
// ----------------------------------------------------------------------------
// Start code packetizer channels
// Valid/ready channels for stream bytes in and packetizer results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface hscp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface hscp_out_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  out_byte;
	logic [15:0] package_number;
	logic [15:0] frame_number;
	logic        last;

	modport source (output valid, output kind, output out_byte, output package_number,
		output frame_number, output last, input ready);
	modport sink (input valid, input kind, input out_byte, input package_number,
		input frame_number, input last, output ready);
endinterface

`default_nettype wire

@@ rtl/h264_start_code_packetizer.sv @@
// ----------------------------------------------------------------------------
// H.264 start code packetizer
// Scans an Annex B byte stream for start codes and turns it into payload
// bytes and package close events.
// ----------------------------------------------------------------------------
// Flow: a byte that produces no result (a zero that may open a start
// code, a header body byte other than the last PPS byte, a dropped unit
// type) is taken without starting the sequencer. A byte that produces
// results holds the input until its last result has been issued, because
// every program step and every capacity close is one result and leaves
// through a single output register. Stalls on the result channel hold
// the input as well. There is no clearing pass after reset; the header
// store needs none.
`default_nettype none

module h264_start_code_packetizer (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_we,
	input  wire  [hscp_pkg::CAP_W-1:0]     cfg_wdata,
	hscp_in_if.sink                        stream,
	hscp_out_if.source                     result
);

	// The scanner owns the start code pattern, the SPS/PPS header store and
	// the choice of program for each accepted byte. It only takes a request
	// while the sequencer is idle, so one byte's results never interleave
	// with the next byte's.
	hscp_pkg::start_req_t               req;
	hscp_pkg::seq_stat_t                stat;
	logic [hscp_pkg::HDR_AW-1:0]        hdr_idx;
	logic [7:0]                         hdr_byte;

	hscp_scanner u_scanner (
		.clk     (clk),
		.arst_n  (arst_n),
		.stream  (stream),
		.stat    (stat),
		.req     (req),
		.rd_idx  (hdr_idx),
		.rd_byte (hdr_byte)
	);

	// The sequencer runs a short program from its control ROM: pass-through
	// zeros, start code insertion, package closes and the header replay.
	// After every appended byte it checks the package fill against the
	// clamped capacity and, when full, slips in a close before continuing.
	// Package and frame numbers advance before the close is reported, so a
	// close carries the new numbers.
	hscp_sequencer u_sequencer (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.stat      (stat),
		.hdr_idx   (hdr_idx),
		.hdr_byte  (hdr_byte),
		.result    (result)
	);

endmodule

`default_nettype wire

@@ rtl/hscp_scanner.sv @@
// ----------------------------------------------------------------------------
// Start code scanner
// Tracks the start code pattern, collects SPS and PPS bytes into the header
// store and picks the sequencer program each accepted byte needs.
// ----------------------------------------------------------------------------
`default_nettype none

module hscp_scanner (
	input  wire                             clk,
	input  wire                             arst_n,
	hscp_in_if.sink                         stream,
	input  wire  hscp_pkg::seq_stat_t       stat,
	output hscp_pkg::start_req_t            req,
	input  wire  [hscp_pkg::HDR_AW-1:0]     rd_idx,
	output logic [7:0]                      rd_byte
);

	localparam logic [2:0] PH_Z0   = 3'd0;
	localparam logic [2:0] PH_Z1   = 3'd1;
	localparam logic [2:0] PH_Z2   = 3'd2;
	localparam logic [2:0] PH_Z3   = 3'd3;
	localparam logic [2:0] PH_TYPE = 3'd4;
	localparam logic [2:0] PH_SPS  = 3'd5;
	localparam logic [2:0] PH_PPS  = 3'd6;

	logic [2:0]                   phase_q, phase_d;
	logic [hscp_pkg::HDR_AW-1:0]  fill_q, fill_d, fill_inc;
	logic                         accept;
	logic                         wr_en;
	logic [7:0]                   b;
	logic [7:0]                   store_q [hscp_pkg::HEADER_BYTES];

	assign stream.ready = stat.idle;
	assign accept       = stream.valid && stat.idle;
	assign b            = stream.in_byte;
	assign fill_inc     = fill_q + 1'b1;

	always_comb begin
		phase_d   = phase_q;
		fill_d    = fill_q;
		wr_en     = 1'b0;
		req.valid = 1'b0;
		req.entry = hscp_pkg::UC_BYTE;
		req.data  = b;
		if (accept) begin
			unique case (phase_q)
				PH_Z0: begin
					if (b == hscp_pkg::BYTE_ZERO) begin
						phase_d = PH_Z1;
					end else if (stat.saving) begin
						req.valid = 1'b1;
						req.entry = hscp_pkg::UC_BYTE;
					end
				end
				PH_Z1: begin
					if (b == hscp_pkg::BYTE_ZERO) begin
						phase_d = PH_Z2;
					end else begin
						phase_d   = PH_Z0;
						req.valid = stat.saving;
						req.entry = hscp_pkg::UC_PASS1;
					end
				end
				PH_Z2: begin
					if (b == hscp_pkg::BYTE_ZERO) begin
						phase_d = PH_Z3;
					end else begin
						phase_d   = PH_Z0;
						req.valid = stat.saving;
						req.entry = hscp_pkg::UC_PASS2;
					end
				end
				PH_Z3: begin
					if (b == hscp_pkg::BYTE_ONE) begin
						phase_d = PH_TYPE;
					end else begin
						// A fourth zero does not restart the pattern.
						phase_d   = PH_Z0;
						req.valid = stat.saving;
						req.entry = hscp_pkg::UC_PASS3;
					end
				end
				PH_TYPE: begin
					phase_d = PH_Z0;
					priority if (b == hscp_pkg::TYPE_CLOSE) begin
						req.valid = 1'b1;
						req.entry = hscp_pkg::UC_CLOSE;
					end else if (b == hscp_pkg::TYPE_KEY) begin
						req.valid = 1'b1;
						req.entry = hscp_pkg::UC_KEY;
					end else if (b == hscp_pkg::TYPE_SPS) begin
						phase_d = PH_SPS;
						fill_d  = hscp_pkg::HDR_SPS_BODY;
					end else if (b == hscp_pkg::TYPE_PPS) begin
						phase_d = PH_PPS;
						fill_d  = hscp_pkg::HDR_PPS_BODY;
					end else if (b == hscp_pkg::TYPE_AUD) begin
						req.valid = 1'b1;
						req.entry = hscp_pkg::UC_START;
					end
				end
				PH_SPS: begin
					wr_en  = 1'b1;
					fill_d = fill_inc;
					if (fill_inc >= hscp_pkg::HDR_SPS_DONE) begin
						phase_d = PH_Z0;
					end
				end
				PH_PPS: begin
					wr_en  = 1'b1;
					fill_d = fill_inc;
					if (fill_inc >= hscp_pkg::HDR_PPS_DONE) begin
						phase_d   = PH_Z0;
						req.valid = 1'b1;
						req.entry = hscp_pkg::UC_HDR;
					end
				end
				default: begin
					phase_d = PH_Z0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_Z0;
			fill_q  <= '0;
		end else begin
			phase_q <= phase_d;
			fill_q  <= fill_d;
		end
	end

	// Header body bytes; start code positions are constants.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[fill_q] <= b;
		end
	end

	always_comb begin
		unique case (rd_idx)
			5'd0, 5'd1, 5'd2, 5'd20, 5'd21, 5'd22: rd_byte = hscp_pkg::BYTE_ZERO;
			5'd3, 5'd23:                           rd_byte = hscp_pkg::BYTE_ONE;
			5'd4:                                  rd_byte = hscp_pkg::TYPE_SPS;
			5'd24:                                 rd_byte = hscp_pkg::TYPE_PPS;
			default:                               rd_byte = store_q[rd_idx];
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/hscp_sequencer.sv @@
// ----------------------------------------------------------------------------
// Packetizer sequencer
// Steps through the control program, emits one result per unstalled cycle
// into the output register, keeps package fill, package and frame counters.
// ----------------------------------------------------------------------------
`default_nettype none

`include "h264_start_code_packetizer_macros.svh"

module hscp_sequencer (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               cfg_we,
	input  wire  [hscp_pkg::CAP_W-1:0]        cfg_wdata,
	input  wire  hscp_pkg::start_req_t        req,
	output hscp_pkg::seq_stat_t               stat,
	output logic [hscp_pkg::HDR_AW-1:0]       hdr_idx,
	input  wire  [7:0]                        hdr_byte,
	hscp_out_if.source                        result
);

	logic                              busy_q;
	logic [hscp_pkg::UC_AW-1:0]        pc_q;
	logic                              pend_q;
	logic                              pend_last_q;
	logic [hscp_pkg::HDR_AW-1:0]       hdr_idx_q;
	logic [hscp_pkg::FILL_W-1:0]       fill_q;
	logic [15:0]                       pkg_q;
	logic [15:0]                       frm_q;
	logic                              saving_q;
	logic [hscp_pkg::CAP_W-1:0]        cap_q;
	logic [7:0]                        byte_q;

	logic                              out_valid_q;
	logic                              out_kind_q;
	logic [7:0]                        out_byte_q;
	logic [15:0]                       out_pkg_q;
	logic [15:0]                       out_frm_q;
	logic                              out_last_q;

	hscp_pkg::ucode_t                  w;
	logic                              emit;
	logic                              hdr_end;
	logic                              step_done;
	logic [hscp_pkg::CAP_W-1:0]        eff_cap;
	logic [hscp_pkg::CAP_W-1:0]        fill_inc;
	logic                              auto_close;
	logic [15:0]                       pkg_inc;
	logic [15:0]                       frm_inc;
	logic [7:0]                        src_byte;
	logic                              res_kind;
	logic [7:0]                        res_byte;
	logic [15:0]                       res_pkg;
	logic [15:0]                       res_frm;
	logic                              last_c;

	assign w         = hscp_pkg::uc_rom(pc_q);
	assign emit      = busy_q && (!out_valid_q || result.ready);
	assign hdr_end   = (hdr_idx_q == hscp_pkg::HDR_LAST);
	assign step_done = w.fin && (!w.hdr_loop || hdr_end);
	assign fill_inc  = {1'b0, fill_q} + 1'b1;
	assign pkg_inc   = pkg_q + 1'b1;
	assign frm_inc   = frm_q + 1'b1;

	assign stat.idle   = !busy_q;
	assign stat.saving = saving_q;
	assign hdr_idx     = hdr_idx_q;

	always_comb begin
		if (cap_q < hscp_pkg::CAP_MIN) begin
			eff_cap = hscp_pkg::CAP_MIN;
		end else if (cap_q > hscp_pkg::CAP_MAX) begin
			eff_cap = hscp_pkg::CAP_MAX;
		end else begin
			eff_cap = cap_q;
		end
	end

	assign auto_close = (fill_inc >= eff_cap);

	always_comb begin
		unique case (w.src)
			hscp_pkg::SRC_ZERO: src_byte = hscp_pkg::BYTE_ZERO;
			hscp_pkg::SRC_ONE:  src_byte = hscp_pkg::BYTE_ONE;
			hscp_pkg::SRC_BYTE: src_byte = byte_q;
			hscp_pkg::SRC_HDR:  src_byte = hdr_byte;
			default:            src_byte = byte_q;
		endcase
	end

	// A pending capacity close is emitted before the program moves on.
	always_comb begin
		if (pend_q) begin
			res_kind = hscp_pkg::KIND_CLOSE;
			res_byte = '0;
			res_pkg  = pkg_inc;
			res_frm  = frm_q;
			last_c   = pend_last_q;
		end else if (w.op == hscp_pkg::OP_CLOSE) begin
			res_kind = hscp_pkg::KIND_CLOSE;
			res_byte = '0;
			res_pkg  = pkg_inc;
			res_frm  = w.new_frame ? frm_inc : frm_q;
			last_c   = step_done;
		end else begin
			res_kind = hscp_pkg::KIND_BYTE;
			res_byte = src_byte;
			res_pkg  = '0;
			res_frm  = '0;
			last_c   = step_done && !auto_close;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pc_q        <= hscp_pkg::UC_BYTE;
			pend_q      <= 1'b0;
			pend_last_q <= 1'b0;
			hdr_idx_q   <= '0;
			fill_q      <= '0;
			pkg_q       <= '0;
			frm_q       <= '0;
			saving_q    <= 1'b0;
			cap_q       <= hscp_pkg::CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (!busy_q) begin
				if (req.valid) begin
					busy_q    <= 1'b1;
					pc_q      <= req.entry;
					hdr_idx_q <= '0;
				end
			end else if (emit) begin
				if (pend_q) begin
					pkg_q  <= pkg_inc;
					fill_q <= '0;
					pend_q <= 1'b0;
					if (pend_last_q) begin
						busy_q <= 1'b0;
					end
				end else if (w.op == hscp_pkg::OP_CLOSE) begin
					pkg_q  <= pkg_inc;
					fill_q <= '0;
					pc_q   <= w.nxt;
					if (w.new_frame) begin
						frm_q <= frm_inc;
					end
					if (w.save_on) begin
						saving_q <= 1'b1;
					end
					if (step_done) begin
						busy_q <= 1'b0;
					end
				end else begin
					fill_q <= fill_inc[hscp_pkg::FILL_W-1:0];
					if (auto_close) begin
						pend_q      <= 1'b1;
						pend_last_q <= step_done;
					end else if (step_done) begin
						busy_q <= 1'b0;
					end
					if (w.hdr_loop && !hdr_end) begin
						hdr_idx_q <= hdr_idx_q + 1'b1;
					end else begin
						pc_q <= w.nxt;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && req.valid) begin
			byte_q <= req.data;
		end
		if (emit) begin
			out_kind_q <= res_kind;
			out_byte_q <= res_byte;
			out_pkg_q  <= res_pkg;
			out_frm_q  <= res_frm;
			out_last_q <= last_c;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.kind           = out_kind_q;
	assign result.out_byte       = out_byte_q;
	assign result.package_number = out_pkg_q;
	assign result.frame_number   = out_frm_q;
	assign result.last           = out_last_q;

	`HSCP_ASSERT_IMP(a_idle_no_pend, clk, arst_n, !busy_q, !pend_q)
	`HSCP_ASSERT_IMP(a_pc_in_program, clk, arst_n, busy_q, pc_q <= hscp_pkg::UC_LAST)
	`HSCP_ASSERT_IMP(a_hdr_idx_range, clk, arst_n, busy_q, hdr_idx_q <= hscp_pkg::HDR_LAST)
	`HSCP_ASSERT_NXT(a_last_ends_run, clk, arst_n, emit && last_c, !busy_q)
	`HSCP_ASSERT_NXT(a_pend_is_close, clk, arst_n, emit && pend_q, out_valid_q && out_kind_q == hscp_pkg::KIND_CLOSE)

endmodule

`default_nettype wire
